// File: hdl/uvst_pkg.sv
// Shared types and codes for the unique value set table.
// Holds the item structs, action and status codes, and the controller state type.
// No dependencies.
`default_nettype none

package uvst_pkg;

  localparam int VALUE_W = 32;
  localparam int ROW_W   = VALUE_W + 1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_ALTER  = 2'd2,
    ACT_SEARCH = 2'd3
  } action_e;

  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_PRESENT     = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND   = 3'd2;
  localparam logic [2:0] STAT_FULL        = 3'd3;
  localparam logic [2:0] STAT_NEW_PRESENT = 3'd4;

  typedef struct packed {
    action_e                    action;
    logic signed [VALUE_W-1:0]  key;
    logic signed [VALUE_W-1:0]  new_value;
  } in_item_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] status;
    logic [4:0] entry_count;
  } out_item_t;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_SCAN,
    FSM_SETTLE,
    FSM_COMMIT
  } fsm_e;

endpackage

`default_nettype wire

// File: hdl/unique_value_set_table.sv
// Unique value set table: a bounded set of distinct signed 32-bit values.
// Each input item is an insert, remove, alter or search request. Each result
// item carries a success flag, a status code and the entry count afterward.
// Both channels use valid and stall; an item moves at a rising edge where
// valid is high and stall is low. Input items are the in_item struct and
// result items the out_item struct, both from uvst_pkg.
// After reset, a clearing pass writes every row of the entry memory, one row
// per cycle, while in_stall stays high.
// Each item then scans all ENTRIES rows through the single read port of the
// entry memory, one row per cycle, then settles and commits at most one write.
// An item passes through the scan, settle and commit states before the next
// item is accepted; in_stall stays high until its commit is taken.
// The result sits in an output register; the next item may be accepted and
// scanned while it waits. If out_stall holds, the following commit waits.
// Depends on uvst_pkg, uvst_mem and uvst_ctrl.
`default_nettype none

module unique_value_set_table #(
  parameter int ENTRIES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire uvst_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output uvst_pkg::out_item_t       out_item
);

  import uvst_pkg::*;

  localparam int AW = $clog2(ENTRIES);

  logic              res_valid;
  logic              res_ready;
  out_item_t         res_item;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [ROW_W-1:0]  mem_rdata;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r;

  uvst_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (ROW_W),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  uvst_ctrl #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: hdl/uvst_mem.sv
// Entry memory of the unique value set table: one write port and one read port.
// Each row holds a valid flag above a stored value; read data is registered.
// Depends on nothing beyond its parameters.
`default_nettype none

module uvst_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 33,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/uvst_ctrl.sv
// Controller of the unique value set table: clearing pass, memory scan,
// match and free-slot tracking, and at most one write-back per item.
// Depends on uvst_pkg and drives the uvst_mem ports.
`default_nettype none

module uvst_ctrl #(
  parameter int ENTRIES = 16,
  parameter int AW      = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire uvst_pkg::in_item_t        in_item,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output uvst_pkg::out_item_t            res_item,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output logic [uvst_pkg::ROW_W-1:0]     mem_wdata,
  output logic                           mem_re,
  output logic [AW-1:0]                  mem_raddr,
  input  wire logic [uvst_pkg::ROW_W-1:0] mem_rdata
);

  import uvst_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  fsm_e           state_r, state_nxt;
  in_item_t       item_r, item_nxt;
  logic [AW-1:0]  addr_r, addr_nxt;
  logic           rd_vld_r;
  logic [AW-1:0]  rd_addr_r;
  logic           hit_r, hit_nxt;
  logic [AW-1:0]  hit_idx_r, hit_idx_nxt;
  logic           nv_hit_r, nv_hit_nxt;
  logic           free_r, free_nxt;
  logic [AW-1:0]  free_idx_r, free_idx_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  logic               accept;
  logic               row_valid;
  logic [VALUE_W-1:0] row_value;
  logic               res_ok;
  logic [2:0]         res_status;
  logic               wr_commit;
  logic [AW-1:0]      wr_addr;
  logic [ROW_W-1:0]   wr_row;
  logic [CW-1:0]      cnt_after;
  logic [CW+4:0]      cnt_wide;

  assign accept    = in_valid && (state_r == FSM_IDLE);
  assign row_valid = mem_rdata[ROW_W-1];
  assign row_value = mem_rdata[VALUE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FSM_CLEAR;
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
      nv_hit_r <= 1'b0;
      free_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      rd_vld_r <= (state_r == FSM_SCAN);
      hit_r    <= hit_nxt;
      nv_hit_r <= nv_hit_nxt;
      free_r   <= free_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    rd_addr_r  <= addr_r;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_CLEAR: begin
        if (addr_r == LAST) state_nxt = FSM_IDLE;
      end
      FSM_IDLE: begin
        if (accept) state_nxt = FSM_SCAN;
      end
      FSM_SCAN: begin
        if (addr_r == LAST) state_nxt = FSM_SETTLE;
      end
      FSM_SETTLE: begin
        state_nxt = FSM_COMMIT;
      end
      FSM_COMMIT: begin
        if (res_ready) state_nxt = FSM_IDLE;
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    item_nxt     = item_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    nv_hit_nxt   = nv_hit_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    if (accept) begin
      item_nxt   = in_item;
      hit_nxt    = 1'b0;
      nv_hit_nxt = 1'b0;
      free_nxt   = 1'b0;
    end else if (rd_vld_r) begin
      if (row_valid && (row_value == $unsigned(item_r.key))) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = rd_addr_r;
      end
      if (row_valid && (row_value == $unsigned(item_r.new_value))) begin
        nv_hit_nxt = 1'b1;
      end
      if (!row_valid && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = rd_addr_r;
      end
    end
  end

  always_comb begin
    res_ok     = 1'b0;
    res_status = STAT_OK;
    wr_commit  = 1'b0;
    wr_addr    = hit_idx_r;
    wr_row     = {1'b1, $unsigned(item_r.key)};
    cnt_after  = cnt_r;
    unique case (item_r.action)
      ACT_INSERT: begin
        if (hit_r) begin
          res_status = STAT_PRESENT;
        end else if (!free_r) begin
          res_status = STAT_FULL;
        end else begin
          res_ok    = 1'b1;
          wr_commit = 1'b1;
          wr_addr   = free_idx_r;
          cnt_after = cnt_r + CW'(1);
        end
      end
      ACT_REMOVE: begin
        if (!hit_r) begin
          res_status = STAT_NOT_FOUND;
        end else begin
          res_ok    = 1'b1;
          wr_commit = 1'b1;
          wr_row    = {1'b0, $unsigned(item_r.key)};
          cnt_after = cnt_r - CW'(1);
        end
      end
      ACT_ALTER: begin
        if (!hit_r) begin
          res_status = STAT_NOT_FOUND;
        end else if (nv_hit_r) begin
          res_status = STAT_NEW_PRESENT;
        end else begin
          res_ok    = 1'b1;
          wr_commit = 1'b1;
          wr_row    = {1'b1, $unsigned(item_r.new_value)};
        end
      end
      ACT_SEARCH: begin
        if (hit_r) begin
          res_ok = 1'b1;
        end else begin
          res_status = STAT_NOT_FOUND;
        end
      end
      default: begin
        res_status = STAT_OK;
      end
    endcase
  end

  always_comb begin
    addr_nxt  = addr_r;
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = wr_row;
    mem_re    = (state_r == FSM_SCAN);
    mem_raddr = addr_r;
    in_stall  = (state_r != FSM_IDLE);
    res_valid = (state_r == FSM_COMMIT);
    cnt_nxt   = cnt_r;
    cnt_wide  = (CW + 5)'(cnt_after);
    res_item.ok          = res_ok;
    res_item.status      = res_status;
    res_item.entry_count = cnt_wide[4:0];
    unique case (state_r)
      FSM_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = '0;
        addr_nxt  = (addr_r == LAST) ? '0 : addr_r + AW'(1);
      end
      FSM_IDLE: begin
        addr_nxt = '0;
      end
      FSM_SCAN: begin
        addr_nxt = (addr_r == LAST) ? '0 : addr_r + AW'(1);
      end
      FSM_SETTLE: begin
        addr_nxt = '0;
      end
      FSM_COMMIT: begin
        if (res_ready) begin
          mem_we  = wr_commit;
          cnt_nxt = cnt_after;
        end
      end
      default: begin
        addr_nxt = '0;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ENTRIES))
    else $error("Entry count exceeds the table size.");

  a_insert_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_COMMIT && res_ok && item_r.action == ACT_INSERT) |-> free_r)
    else $error("Insert succeeded without a free slot.");

  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == FSM_SCAN))
    else $error("Accepted item did not start a scan.");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_IDLE) |-> !rd_vld_r)
    else $error("Read data pending while idle.");

endmodule

`default_nettype wire
